// ===== rtl/core/slid_pkg.sv =====
// Shared types, codes and microcode for the sorted list insert/delete unit.
// Holds the transaction structs, the control word format and the control store.
// No dependencies.
package slid_pkg;

   localparam int SLID_CAPACITY = 16;
   localparam int VALUE_W       = 32;
   localparam int INDEX_W       = 4;
   localparam int COUNT_OUT_W   = 5;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      action_type                  action;
      logic signed [VALUE_W-1:0]   value;
      logic        [INDEX_W-1:0]   index;
   } req_payload_type;

   typedef struct packed {
      status_type                    status;
      logic        [COUNT_OUT_W-1:0] entry_count;
      logic        [COUNT_OUT_W-1:0] removed_count;
      logic signed [VALUE_W-1:0]     read_value;
   } rsp_payload_type;

   // Microprogram addresses.
   typedef enum logic [3:0] {
      STEP_IDLE        = 4'd0,
      STEP_INS_CHECK   = 4'd1,
      STEP_INS_READ    = 4'd2,
      STEP_INS_COMPARE = 4'd3,
      STEP_INS_PLACE   = 4'd4,
      STEP_DEL_INIT    = 4'd5,
      STEP_DEL_READ    = 4'd6,
      STEP_DEL_COMPARE = 4'd7,
      STEP_DEL_FINISH  = 4'd8,
      STEP_RD_CHECK    = 4'd9,
      STEP_RD_CAPTURE  = 4'd10,
      STEP_EMIT        = 4'd11
   } step_type;

   typedef enum logic [3:0] {
      UOP_ACCEPT,
      UOP_INS_INIT,
      UOP_INS_READ,
      UOP_INS_SHIFT,
      UOP_INS_PLACE,
      UOP_DEL_INIT,
      UOP_DEL_READ,
      UOP_DEL_STEP,
      UOP_DEL_FINISH,
      UOP_RD_READ,
      UOP_RD_CAPTURE,
      UOP_EMIT
   } uop_type;

   typedef enum logic [3:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_IF_FULL,
      JMP_IF_K_ZERO,
      JMP_IF_GREATER,
      JMP_IF_SCAN_END,
      JMP_IF_BAD_INDEX,
      JMP_DISPATCH,
      JMP_IF_OUT_FREE
   } jump_type;

   typedef struct packed {
      uop_type  uop;
      jump_type jump;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic       req_valid;
      action_type action;
      logic       full;
      logic       k_zero;
      logic       greater;
      logic       scan_end;
      logic       bad_index;
      logic       out_free;
   } flags_type;

   // Control store: one word per microprogram step.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type word;
      word = '{UOP_ACCEPT, JMP_DISPATCH, STEP_IDLE};
      unique case (step)
         STEP_IDLE:        word = '{UOP_ACCEPT,     JMP_DISPATCH,     STEP_IDLE};
         STEP_INS_CHECK:   word = '{UOP_INS_INIT,   JMP_IF_FULL,      STEP_EMIT};
         STEP_INS_READ:    word = '{UOP_INS_READ,   JMP_IF_K_ZERO,    STEP_INS_PLACE};
         STEP_INS_COMPARE: word = '{UOP_INS_SHIFT,  JMP_IF_GREATER,   STEP_INS_READ};
         STEP_INS_PLACE:   word = '{UOP_INS_PLACE,  JMP_GOTO,         STEP_EMIT};
         STEP_DEL_INIT:    word = '{UOP_DEL_INIT,   JMP_NEXT,         STEP_IDLE};
         STEP_DEL_READ:    word = '{UOP_DEL_READ,   JMP_IF_SCAN_END,  STEP_DEL_FINISH};
         STEP_DEL_COMPARE: word = '{UOP_DEL_STEP,   JMP_GOTO,         STEP_DEL_READ};
         STEP_DEL_FINISH:  word = '{UOP_DEL_FINISH, JMP_GOTO,         STEP_EMIT};
         STEP_RD_CHECK:    word = '{UOP_RD_READ,    JMP_IF_BAD_INDEX, STEP_EMIT};
         STEP_RD_CAPTURE:  word = '{UOP_RD_CAPTURE, JMP_GOTO,         STEP_EMIT};
         STEP_EMIT:        word = '{UOP_EMIT,       JMP_IF_OUT_FREE,  STEP_IDLE};
         default:          word = '{UOP_ACCEPT,     JMP_DISPATCH,     STEP_IDLE};
      endcase
      return word;
   endfunction

   // Entry point of each action's routine.
   function automatic step_type dispatch_target(input action_type action);
      step_type step;
      unique case (action)
         ACT_INSERT: step = STEP_INS_CHECK;
         ACT_DELETE: step = STEP_DEL_INIT;
         ACT_READ:   step = STEP_RD_CHECK;
         ACT_NOP:    step = STEP_EMIT;
         default:    step = STEP_EMIT;
      endcase
      return step;
   endfunction

endpackage

// ===== rtl/core/slid_seq.sv =====
// Microprogram sequencer: step counter, control store lookup and jump logic.
// Depends on slid_pkg.
module slid_seq
   import slid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  flags_type     flags,
   output ctrl_word_type ctrl
);

   step_type step_ff;
   step_type step_in;
   step_type next_step;

   assign next_step = step_type'(step_ff + 4'd1);

   always_comb begin
      step_in = step_ff;
      unique case (ctrl.jump)
         JMP_NEXT:         step_in = next_step;
         JMP_GOTO:         step_in = ctrl.target;
         JMP_IF_FULL:      step_in = flags.full      ? ctrl.target : next_step;
         JMP_IF_K_ZERO:    step_in = flags.k_zero    ? ctrl.target : next_step;
         JMP_IF_GREATER:   step_in = flags.greater   ? ctrl.target : next_step;
         JMP_IF_SCAN_END:  step_in = flags.scan_end  ? ctrl.target : next_step;
         JMP_IF_BAD_INDEX: step_in = flags.bad_index ? ctrl.target : next_step;
         // hold until a transaction arrives
         JMP_DISPATCH:     step_in = flags.req_valid ? dispatch_target(flags.action) : step_ff;
         // hold until the result register can take the result
         JMP_IF_OUT_FREE:  step_in = flags.out_free  ? ctrl.target : step_ff;
         default:          step_in = STEP_IDLE;
      endcase
   end

   always_comb begin
      ctrl = ucode_rom(step_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/core/slid_dp.sv =====
// Datapath: entry memory, pointers, count, status and the result register.
// Driven by the control word from slid_seq; depends on slid_pkg.
module slid_dp
   import slid_pkg::*;
#(
   parameter int CAPACITY = SLID_CAPACITY
)
(
   input  logic            clock,
   input  logic            reset,
   input  ctrl_word_type   ctrl,
   output flags_type       flags,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

   logic signed [VALUE_W-1:0] entry_mem_ff [CAPACITY];
   logic signed [VALUE_W-1:0] rdata_ff;

   logic [CW-1:0]             count_ff,   count_in;
   logic [CW-1:0]             k_ff,       k_in;
   logic [CW-1:0]             wr_ff,      wr_in;
   logic [CW-1:0]             removed_ff, removed_in;
   logic signed [VALUE_W-1:0] value_ff,   value_in;
   logic [INDEX_W-1:0]        index_ff,   index_in;
   status_type                status_ff,  status_in;
   logic signed [VALUE_W-1:0] rdval_ff,   rdval_in;
   rsp_payload_type           rsp_ff,     rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]             k_dec;
   logic [AW-1:0]             raddr;
   logic                      wen;
   logic [AW-1:0]             waddr;
   logic signed [VALUE_W-1:0] wdata;
   logic                      accept;
   logic                      greater;
   logic                      equal;
   logic                      full;
   logic                      out_free;

   assign k_dec    = k_ff - CW'(1);
   assign accept   = (ctrl.uop == UOP_ACCEPT) && req_valid;
   assign greater  = rdata_ff > value_ff;
   assign equal    = rdata_ff == value_ff;
   assign full     = count_ff >= CW'(CAPACITY);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // hold off transactions while reset is applied
   assign req_ready   = (ctrl.uop == UOP_ACCEPT) && !reset;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      flags.req_valid = req_valid;
      flags.action    = req_payload.action;
      flags.full      = full;
      flags.k_zero    = (k_ff == '0);
      flags.greater   = greater;
      flags.scan_end  = (k_ff == count_ff);
      flags.bad_index = CMPW'(index_ff) >= CMPW'(count_ff);
      flags.out_free  = out_free;
   end

   // memory address and write strobe
   always_comb begin
      raddr = k_ff[AW-1:0];
      wen   = 1'b0;
      waddr = k_ff[AW-1:0];
      wdata = rdata_ff;
      unique case (ctrl.uop)
         UOP_INS_READ: raddr = k_dec[AW-1:0];
         UOP_RD_READ:  raddr = AW'(index_ff);
         UOP_INS_SHIFT: begin
            wen = greater;
         end
         UOP_INS_PLACE: begin
            wen   = 1'b1;
            wdata = value_ff;
         end
         UOP_DEL_STEP: begin
            wen   = !equal;
            waddr = wr_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      k_in         = k_ff;
      wr_in        = wr_ff;
      removed_in   = removed_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      status_in    = status_ff;
      rdval_in     = rdval_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (ctrl.uop)
         UOP_ACCEPT: begin
            if (accept) begin
               value_in   = req_payload.value;
               index_in   = req_payload.index;
               status_in  = ST_OK;
               removed_in = '0;
               rdval_in   = '0;
            end
         end
         UOP_INS_INIT: begin
            k_in      = count_ff;
            status_in = full ? ST_FULL : ST_OK;
         end
         UOP_INS_SHIFT: begin
            if (greater) begin
               k_in = k_dec;
            end
         end
         UOP_INS_PLACE: begin
            count_in = count_ff + CW'(1);
         end
         UOP_DEL_INIT: begin
            k_in  = '0;
            wr_in = '0;
         end
         // drop matches, compact the rest down to the write pointer
         UOP_DEL_STEP: begin
            k_in = k_ff + CW'(1);
            if (equal) begin
               removed_in = removed_ff + CW'(1);
            end else begin
               wr_in = wr_ff + CW'(1);
            end
         end
         UOP_DEL_FINISH: begin
            count_in  = count_ff - removed_ff;
            status_in = (removed_ff == '0) ? ST_NOT_FOUND : ST_OK;
         end
         UOP_RD_READ: begin
            if (CMPW'(index_ff) >= CMPW'(count_ff)) begin
               status_in = ST_BAD_INDEX;
            end
         end
         UOP_RD_CAPTURE: begin
            rdval_in = rdata_ff;
         end
         UOP_EMIT: begin
            if (out_free) begin
               rsp_in.status        = status_ff;
               rsp_in.entry_count   = COUNT_OUT_W'(count_ff);
               rsp_in.removed_count = COUNT_OUT_W'(removed_ff);
               rsp_in.read_value    = rdval_ff;
               rsp_valid_in         = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         entry_mem_ff[waddr] <= wdata;
      end
      rdata_ff <= entry_mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      wr_ff      <= wr_in;
      removed_ff <= removed_in;
      value_ff   <= value_in;
      index_ff   <= index_in;
      status_ff  <= status_in;
      rdval_ff   <= rdval_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/sorted_list_insert_delete_unit.sv =====
// Top level of the sorted list insert/delete unit: sequencer plus datapath.
// Depends on slid_pkg, slid_seq and slid_dp.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_payload (action, value, index)
//   rsp      out        rsp_valid/rsp_ready    rsp_payload (status, counts, read_value)
//
// One transaction at a time, run by a microprogram over an entry memory with one read
// and one write port and registered read data; each entry visited takes a read step
// and a compare step. Insert shifts up each entry above the new value, then places it;
// a full table skips to the result. Delete visits every entry held. Read skips the
// capture step past the end. An unused action goes straight to the result step.
// Reset empties the table and idles the sequencer; the memory is not cleared.
// The result register holds under rsp stall; a new transaction is taken meanwhile,
// and its routine waits at its final step until the register frees.
module sorted_list_insert_delete_unit
   import slid_pkg::*;
#(
   parameter int CAPACITY = SLID_CAPACITY
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   ctrl_word_type ctrl;
   flags_type     flags;

   slid_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   slid_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .flags       (flags),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
